// ===== rtl/ckm_pkg.sv =====
// Shared types and constants for the color key mask with bounding box.
// Used by every module of the block; depends on nothing.
package ckm_pkg;

  // Largest frame side in pixels and the widths that follow from it
  localparam int MAX_DIM = 4096;
  localparam int CNT_W   = $clog2(MAX_DIM);
  localparam int DIM_W   = 13;
  localparam int PIX_W   = 32;
  localparam int TOL_W   = 8;
  localparam int IDX_W   = 3;
  localparam int OUT_W   = 56;

  // Pixel formats
  typedef enum logic [1:0] {
    MODE_RGBA = 2'd0,
    MODE_GA   = 2'd1,
    MODE_IDX  = 2'd2
  } color_mode_t;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_COLOR_MODE   = 3'd0,
    REG_KEY_COLOR    = 3'd1,
    REG_TOLERANCE    = 3'd2,
    REG_FRAME_WIDTH  = 3'd3,
    REG_FRAME_HEIGHT = 3'd4
  } reg_idx_t;

  // Settings as the datapath uses them, sizes already clamped
  typedef struct packed {
    logic [1:0]       color_mode;
    logic [PIX_W-1:0] key_color;
    logic [TOL_W-1:0] tolerance;
    logic [CNT_W-1:0] col_last;
    logic [CNT_W-1:0] row_last;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic             select_bit;
    logic             frame_last;
    logic             box_empty;
    logic [CNT_W-1:0] box_left;
    logic [CNT_W-1:0] box_top;
    logic [CNT_W-1:0] box_right;
    logic [CNT_W-1:0] box_bottom;
  } res_t;

endpackage

// ===== rtl/ckm_cfg.sv =====
// Configuration registers of the color key mask, with size clamping.
// Depends on ckm_pkg.
module ckm_cfg import ckm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [PIX_W-1:0] cfg_data,
  output cfg_t             cfg
);

  logic [1:0]       color_mode;
  logic [PIX_W-1:0] key_color;
  logic [TOL_W-1:0] tolerance;
  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;

  assign cfg_ready = 1'b1;

  // Take a write; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode   <= '0;
      key_color    <= '0;
      tolerance    <= '0;
      frame_width  <= DIM_W'(1);
      frame_height <= DIM_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COLOR_MODE:   color_mode   <= cfg_data[1:0];
        REG_KEY_COLOR:    key_color    <= cfg_data;
        REG_TOLERANCE:    tolerance    <= cfg_data[TOL_W-1:0];
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp a size to 1..MAX_DIM and give its last position
  function automatic logic [CNT_W-1:0] last_pos(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] m;
    begin
      m = v - DIM_W'(1);
      if (v == '0) begin
        last_pos = '0;
      end else if (v > DIM_W'(MAX_DIM)) begin
        last_pos = CNT_W'(MAX_DIM - 1);
      end else begin
        last_pos = m[CNT_W-1:0];
      end
    end
  endfunction

  assign cfg.color_mode = color_mode;
  assign cfg.key_color  = key_color;
  assign cfg.tolerance  = tolerance;
  assign cfg.col_last   = last_pos(frame_width);
  assign cfg.row_last   = last_pos(frame_height);

endmodule

// ===== rtl/ckm_match.sv =====
// Per-channel tolerance compare of one pixel against the key color.
// Depends on ckm_pkg.
module ckm_match import ckm_pkg::*; (
  input  logic [PIX_W-1:0] pixel,
  input  cfg_t             cfg,
  output logic             select_bit
);

  logic [3:0] chan_ok;

  // Compare each byte lane: |pixel - key| <= tolerance
  always_comb begin
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] d;
    for (int i = 0; i < 4; i++) begin
      a = pixel[8*i +: 8];
      b = cfg.key_color[8*i +: 8];
      d = (a >= b) ? (a - b) : (b - a);
      chan_ok[i] = (d <= cfg.tolerance);
    end
  end

  // Combine the lanes that the format uses
  always_comb begin
    case (cfg.color_mode)
      MODE_RGBA: select_bit = &chan_ok;
      MODE_GA:   select_bit = chan_ok[0] & chan_ok[1];
      MODE_IDX:  select_bit = chan_ok[0];
      default:   select_bit = 1'b0;
    endcase
  end

endmodule

// ===== rtl/ckm_bbox.sv =====
// Raster position counters and running bounding box of selected pixels.
// Depends on ckm_pkg; builds the result item for each pixel.
module ckm_bbox import ckm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  logic select_bit,
  input  cfg_t cfg,
  output res_t res
);

  logic [CNT_W-1:0] column_count, column_count_next;
  logic [CNT_W-1:0] row_count, row_count_next;
  logic             any_selected, any_selected_next;
  logic [CNT_W-1:0] min_column, min_column_next;
  logic [CNT_W-1:0] min_row, min_row_next;
  logic [CNT_W-1:0] max_column, max_column_next;
  logic [CNT_W-1:0] max_row, max_row_next;
  logic             row_end;
  logic             frame_end;

  assign row_end   = (column_count >= cfg.col_last);
  assign frame_end = row_end && (row_count >= cfg.row_last);

  // Fold the current pixel into the box
  always_comb begin
    any_selected_next = any_selected | select_bit;
    min_column_next   = min_column;
    min_row_next      = min_row;
    max_column_next   = max_column;
    max_row_next      = max_row;
    if (select_bit) begin
      if (!any_selected) begin
        min_column_next = column_count;
        max_column_next = column_count;
        min_row_next    = row_count;
        max_row_next    = row_count;
      end else begin
        if (column_count < min_column) min_column_next = column_count;
        if (column_count > max_column) max_column_next = column_count;
        if (row_count < min_row)       min_row_next    = row_count;
        if (row_count > max_row)       max_row_next    = row_count;
      end
    end
  end

  // Advance the raster position
  always_comb begin
    column_count_next = column_count + CNT_W'(1);
    row_count_next    = row_count;
    if (frame_end) begin
      column_count_next = '0;
      row_count_next    = '0;
    end else if (row_end) begin
      column_count_next = '0;
      row_count_next    = row_count + CNT_W'(1);
    end
  end

  // Build the result; the box shows only on the last pixel of a frame
  always_comb begin
    res            = '0;
    res.select_bit = select_bit;
    res.frame_last = frame_end;
    if (frame_end) begin
      if (any_selected_next) begin
        res.box_left   = min_column_next;
        res.box_top    = min_row_next;
        res.box_right  = max_column_next;
        res.box_bottom = max_row_next;
      end else begin
        res.box_empty  = 1'b1;
      end
    end
  end

  // Update state once per item; start over at frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      any_selected <= 1'b0;
      min_column   <= '0;
      min_row      <= '0;
      max_column   <= '0;
      max_row      <= '0;
    end else if (step) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      if (frame_end) begin
        any_selected <= 1'b0;
        min_column   <= '0;
        min_row      <= '0;
        max_column   <= '0;
        max_row      <= '0;
      end else begin
        any_selected <= any_selected_next;
        min_column   <= min_column_next;
        min_row      <= min_row_next;
        max_column   <= max_column_next;
        max_row      <= max_row_next;
      end
    end
  end

  // A frame end clears position and box
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    step && frame_end |=> column_count == '0 && row_count == '0 && !any_selected)
    else $error("state not cleared after frame end");

  // A held box is always well ordered
  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    any_selected |-> min_column <= max_column && min_row <= max_row)
    else $error("bounding box out of order");

  // A non-empty box at frame end is well ordered and an empty box has zero right and bottom edges
  a_result_box: assert property (@(posedge clk) disable iff (rst)
    step && res.frame_last |->
      (res.box_empty ? (res.box_right == '0 && res.box_bottom == '0)
       : (res.box_left <= res.box_right && res.box_top <= res.box_bottom)))
    else $error("bad box in frame end result");

endmodule

// ===== rtl/color_key_mask_with_bbox_unit.sv =====
// Top level of the color key mask with bounding box: stream ports and pipeline.
// Depends on ckm_pkg, ckm_cfg, ckm_match and ckm_bbox.
//
// Takes one pixel per item in raster order and returns one result item per pixel: a select
// bit that is set when every channel that the color mode uses lies within the tolerance of
// the key color, and, on the item for the last pixel of a frame (tlast high), the bounding
// box of all selected pixels of that frame or an empty flag. The block sustains one item per
// clock while the output is not stalled; a result passes through the input register and
// the result register that bracket the compare and box update. Frame size is clamped to
// 1..4096 per side. Write configuration only while no items are in flight.
module color_key_mask_with_bbox_unit import ckm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  // Configuration write channel
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [PIX_W-1:0] cfg_data,
  // Pixel stream in
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [PIX_W-1:0] s_tdata,   // pixel[31:0]
  // Result stream out
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // select_bit[0], box_empty[1], box_left[13:2],
                                      // box_top[25:14], box_right[37:26],
                                      // box_bottom[49:38], zero[55:50]
  output logic             m_tlast    // frame_last
);

  cfg_t             cfg;
  logic             a_valid;
  logic [PIX_W-1:0] a_pixel;
  logic             advance;
  logic             step;
  logic             select_bit;
  res_t             res;
  res_t             out_res;
  logic             out_valid;

  ckm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Pipeline control: the result register is empty or drains this cycle
  assign advance  = !out_valid || m_tready;
  assign s_tready = !a_valid || advance;
  assign step     = a_valid && advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_tready) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      a_pixel <= s_tdata;
    end
  end

  ckm_match u_match (
    .pixel      (a_pixel),
    .cfg        (cfg),
    .select_bit (select_bit)
  );

  ckm_bbox u_bbox (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .select_bit (select_bit),
    .cfg        (cfg),
    .res        (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_res.frame_last;
  assign m_tdata  = {(OUT_W - 2 - 4*CNT_W)'(0), out_res.box_bottom, out_res.box_right,
                     out_res.box_top, out_res.box_left, out_res.box_empty,
                     out_res.select_bit};

  // A stalled item in the input register stays put
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    a_valid && !advance |=> a_valid && $stable(a_pixel))
    else $error("input item lost while stalled");

endmodule
